/* rtl/tournament_branch_predictor_assert.svh */
// assertion macros used by the checker of the branch predictor
`ifndef TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TBP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define TBP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tbp_pkg.sv */
// ----------------------------------------------------------------------------
// tbp_pkg
// Types, constants and counter helpers of the tournament branch predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package tbp_pkg;

    // field and counter widths
    localparam int CTR_W    = 8;
    localparam int CFG_W    = 4;
    localparam int PC_W     = 32;
    localparam int WORD_LSB = 2;

    // result queue geometry
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = 2;
    localparam int OUTQ_CW    = 3;

    typedef logic [CTR_W-1:0] ctr_t;
    typedef logic [CFG_W-1:0] cfg_t;

    // counter width limits and reset value
    localparam cfg_t CFG_RESET = 4'd2;
    localparam cfg_t CFG_MIN   = 4'd2;
    localparam cfg_t CFG_MAX   = 4'd8;

    typedef struct packed {
        logic [PC_W-1:0] branch_address;
        logic            taken;
    } tbp_branch_t;

    typedef struct packed {
        logic predicted_taken;
        logic mispredicted;
        logic used_gshare;
    } tbp_result_t;

    // threshold of a counter of the configured width, width clamped to 2..8
    function automatic ctr_t ctr_half(input cfg_t bits);
        cfg_t n;
        if (bits < CFG_MIN) begin
            n = CFG_MIN;
        end
        else if (bits > CFG_MAX) begin
            n = CFG_MAX;
        end
        else begin
            n = bits;
        end
        return ctr_t'(1) << (n - 1'b1);
    endfunction

    // saturation value: twice the threshold less one
    function automatic ctr_t ctr_top(input ctr_t half);
        return ctr_t'({half, 1'b0} - 1'b1);
    endfunction

    // saturating step; a counter above the top is never raised
    function automatic ctr_t ctr_train(input ctr_t c, input logic up, input ctr_t top);
        ctr_t r;
        r = c;
        if (up) begin
            if (c < top) begin
                r = c + 1'b1;
            end
        end
        else begin
            if (c != '0) begin
                r = c - 1'b1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/tbp_ram.sv */
// ----------------------------------------------------------------------------
// tbp_ram
// Counter table: one write port, one read port, read data registered,
// a read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_ram
    import tbp_pkg::*;
#(
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire ctr_t          wdata,
    input  wire logic [AW-1:0] raddr,
    output ctr_t               rdata
);

    ctr_t mem [DEPTH];
    ctr_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/tbp_outq.sv */
// ----------------------------------------------------------------------------
// tbp_outq
// Small result queue that decouples the table pipeline from the result
// channel; the occupancy is handed back for admission control.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_outq
    import tbp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire tbp_result_t        push_data,
    input  wire logic               pop,
    output logic                    valid,
    output tbp_result_t             head,
    output logic [OUTQ_CW-1:0]      count
);

    tbp_result_t              slot_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CW-1:0]       count_reg, count_next;

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + OUTQ_CW'(push) - OUTQ_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

`default_nettype wire

/* rtl/tournament_branch_predictor.sv */
// ----------------------------------------------------------------------------
// tournament_branch_predictor
// Bimodal and gshare predictors arbitrated by a chooser table, trained on
// resolved branches. Three counter tables in synchronous RAM with a
// read-modify-write pipeline and forwarding of recent writes.
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+----------
//   branch   | branch_valid, branch_stall, branch   | into block
//   result   | result_valid, result_stall, result   | out of block
//   cfg      | cfg_valid, cfg_ready, cfg_data       | into block
//
// One branch per cycle sustained while branch_stall is low; a result goes into
// the result queue from the table pipeline (bimodal and chooser read in the
// transfer cycle, gshare read in stage b, write back in stage c).
// After reset a clearing pass zeroes every table entry with branch_stall
// high; cfg writes are taken throughout.
// A four-entry result queue absorbs result_stall; branch_stall rises when the
// queue plus the branches in flight already fill it.
// ----------------------------------------------------------------------------
`default_nettype none

module tournament_branch_predictor
    import tbp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4096,
    parameter int HISTORY_BITS  = 12
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        branch_valid,
    output logic             branch_stall,
    input  wire tbp_branch_t branch,
    output logic             result_valid,
    input  wire logic        result_stall,
    output tbp_result_t      result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire cfg_t        cfg_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int XW    = (IDX_W > HISTORY_BITS) ? IDX_W : HISTORY_BITS;

    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [HISTORY_BITS-1:0] hist_t;

    // configuration
    cfg_t  counter_bits_reg, counter_bits_next;
    ctr_t  half;
    ctr_t  top;

    // clearing pass
    logic  clearing_reg, clearing_next;
    idx_t  clr_idx_reg, clr_idx_next;

    // histories
    hist_t chist_reg, chist_next;
    hist_t ghist_reg, ghist_next;

    // accept stage
    logic  branch_fire;
    idx_t  word_a;
    idx_t  cidx_a;

    // stage b
    logic  b_valid_reg;
    idx_t  b_bidx_reg;
    idx_t  b_cidx_reg;
    logic  b_taken_reg;
    ctr_t  bim_b;
    ctr_t  chs_b;
    logic  use_g_b;
    idx_t  gidx_b;

    // stage c
    logic  c_valid_reg;
    idx_t  c_bidx_reg;
    idx_t  c_cidx_reg;
    idx_t  c_gidx_reg;
    logic  c_taken_reg;
    logic  c_use_g_reg;
    ctr_t  c_bim_reg;
    ctr_t  c_chs_reg;
    ctr_t  gsh_c;
    logic  bim_pred, gsh_pred, pred;
    logic  bim_ok, gsh_ok;
    logic  bim_we, gsh_we, chs_we;
    ctr_t  bim_wval, gsh_wval, chs_wval;
    tbp_result_t res_c;

    // last committed write of each table
    logic  fw_bim_en_reg, fw_gsh_en_reg, fw_chs_en_reg;
    idx_t  fw_bim_idx_reg, fw_gsh_idx_reg, fw_chs_idx_reg;
    ctr_t  fw_bim_val_reg, fw_gsh_val_reg, fw_chs_val_reg;

    // ram ports
    logic  bim_ram_we, gsh_ram_we, chs_ram_we;
    idx_t  bim_ram_wa, gsh_ram_wa, chs_ram_wa;
    ctr_t  bim_ram_wd, gsh_ram_wd, chs_ram_wd;
    ctr_t  bim_rdata, gsh_rdata, chs_rdata;

    // result queue
    logic               q_pop;
    logic [OUTQ_CW-1:0] q_count;
    logic [OUTQ_CW-1:0] q_load;

    // configuration register
    assign cfg_ready = 1'b1;

    always_comb
    begin
        counter_bits_next = (cfg_valid && cfg_ready) ? cfg_data : counter_bits_reg;
    end

    assign half = ctr_half(counter_bits_reg);
    assign top  = ctr_top(half);

    // clearing pass sequencing
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_idx_next  = clr_idx_reg;
        if (clearing_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == {IDX_W{1'b1}})
            begin
                clearing_next = 1'b0;
            end
        end
    end

    // admission: room for every branch in flight in the result queue
    assign q_load       = q_count + OUTQ_CW'(b_valid_reg) + OUTQ_CW'(c_valid_reg);
    assign branch_stall = clearing_reg || (q_load >= OUTQ_CW'(OUTQ_DEPTH));
    assign branch_fire  = branch_valid && !branch_stall;

    // accept stage indices
    assign word_a = branch.branch_address[WORD_LSB +: IDX_W];
    assign cidx_a = IDX_W'(XW'(word_a) ^ XW'(chist_reg));

    // chooser history shifts on every transfer, gshare history when gshare is used
    always_comb
    begin
        chist_next = chist_reg;
        ghist_next = ghist_reg;
        if (branch_fire)
        begin
            chist_next = {chist_reg[HISTORY_BITS-2:0], branch.taken};
        end
        if (b_valid_reg && use_g_b)
        begin
            ghist_next = {ghist_reg[HISTORY_BITS-2:0], b_taken_reg};
        end
    end

    // stage b: forward the write in stage c, then last cycle's write
    always_comb
    begin
        if (bim_we && (c_bidx_reg == b_bidx_reg))
        begin
            bim_b = bim_wval;
        end
        else if (fw_bim_en_reg && (fw_bim_idx_reg == b_bidx_reg))
        begin
            bim_b = fw_bim_val_reg;
        end
        else
        begin
            bim_b = bim_rdata;
        end

        if (chs_we && (c_cidx_reg == b_cidx_reg))
        begin
            chs_b = chs_wval;
        end
        else if (fw_chs_en_reg && (fw_chs_idx_reg == b_cidx_reg))
        begin
            chs_b = fw_chs_val_reg;
        end
        else
        begin
            chs_b = chs_rdata;
        end
    end

    assign use_g_b = (chs_b >= half);
    assign gidx_b  = IDX_W'(XW'(b_bidx_reg) ^ XW'(ghist_reg));

    // stage c: gshare read lands with last cycle's write still pending
    always_comb
    begin
        if (fw_gsh_en_reg && (fw_gsh_idx_reg == c_gidx_reg))
        begin
            gsh_c = fw_gsh_val_reg;
        end
        else
        begin
            gsh_c = gsh_rdata;
        end
    end

    // stage c: prediction and training
    always_comb
    begin
        bim_pred = (c_bim_reg >= half);
        gsh_pred = (gsh_c >= half);
        pred     = c_use_g_reg ? gsh_pred : bim_pred;
        bim_ok   = (bim_pred == c_taken_reg);
        gsh_ok   = (gsh_pred == c_taken_reg);

        bim_we   = c_valid_reg && !c_use_g_reg;
        gsh_we   = c_valid_reg && c_use_g_reg;
        chs_we   = c_valid_reg;
        bim_wval = ctr_train(c_bim_reg, c_taken_reg, top);
        gsh_wval = ctr_train(gsh_c, c_taken_reg, top);

        if (gsh_ok && !bim_ok)
        begin
            chs_wval = ctr_train(c_chs_reg, 1'b1, top);
        end
        else if (bim_ok && !gsh_ok)
        begin
            chs_wval = ctr_train(c_chs_reg, 1'b0, top);
        end
        else
        begin
            chs_wval = c_chs_reg;
        end

        res_c.predicted_taken = pred;
        res_c.mispredicted    = (pred != c_taken_reg);
        res_c.used_gshare     = c_use_g_reg;
    end

    // ram write ports, the clearing pass takes them after reset
    always_comb
    begin
        bim_ram_we = clearing_reg || bim_we;
        gsh_ram_we = clearing_reg || gsh_we;
        chs_ram_we = clearing_reg || chs_we;
        bim_ram_wa = clearing_reg ? clr_idx_reg : c_bidx_reg;
        gsh_ram_wa = clearing_reg ? clr_idx_reg : c_gidx_reg;
        chs_ram_wa = clearing_reg ? clr_idx_reg : c_cidx_reg;
        bim_ram_wd = clearing_reg ? '0 : bim_wval;
        gsh_ram_wd = clearing_reg ? '0 : gsh_wval;
        chs_ram_wd = clearing_reg ? '0 : chs_wval;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_bits_reg <= CFG_RESET;
            clearing_reg     <= 1'b1;
            clr_idx_reg      <= '0;
            chist_reg        <= '0;
            ghist_reg        <= '0;
            b_valid_reg      <= 1'b0;
            c_valid_reg      <= 1'b0;
            fw_bim_en_reg    <= 1'b0;
            fw_gsh_en_reg    <= 1'b0;
            fw_chs_en_reg    <= 1'b0;
        end
        else
        begin
            counter_bits_reg <= counter_bits_next;
            clearing_reg     <= clearing_next;
            clr_idx_reg      <= clr_idx_next;
            chist_reg        <= chist_next;
            ghist_reg        <= ghist_next;
            b_valid_reg      <= branch_fire;
            c_valid_reg      <= b_valid_reg;
            fw_bim_en_reg    <= bim_we;
            fw_gsh_en_reg    <= gsh_we;
            fw_chs_en_reg    <= chs_we;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        b_bidx_reg     <= word_a;
        b_cidx_reg     <= cidx_a;
        b_taken_reg    <= branch.taken;

        c_bidx_reg     <= b_bidx_reg;
        c_cidx_reg     <= b_cidx_reg;
        c_gidx_reg     <= gidx_b;
        c_taken_reg    <= b_taken_reg;
        c_use_g_reg    <= use_g_b;
        c_bim_reg      <= bim_b;
        c_chs_reg      <= chs_b;

        fw_bim_idx_reg <= c_bidx_reg;
        fw_gsh_idx_reg <= c_gidx_reg;
        fw_chs_idx_reg <= c_cidx_reg;
        fw_bim_val_reg <= bim_wval;
        fw_gsh_val_reg <= gsh_wval;
        fw_chs_val_reg <= chs_wval;
    end

    // counter tables
    tbp_ram #(.DEPTH(TABLE_ENTRIES)) u_bim_ram (
        .clk   (clk),
        .we    (bim_ram_we),
        .waddr (bim_ram_wa),
        .wdata (bim_ram_wd),
        .raddr (word_a),
        .rdata (bim_rdata)
    );

    tbp_ram #(.DEPTH(TABLE_ENTRIES)) u_chs_ram (
        .clk   (clk),
        .we    (chs_ram_we),
        .waddr (chs_ram_wa),
        .wdata (chs_ram_wd),
        .raddr (cidx_a),
        .rdata (chs_rdata)
    );

    tbp_ram #(.DEPTH(TABLE_ENTRIES)) u_gsh_ram (
        .clk   (clk),
        .we    (gsh_ram_we),
        .waddr (gsh_ram_wa),
        .wdata (gsh_ram_wd),
        .raddr (gidx_b),
        .rdata (gsh_rdata)
    );

    // result queue
    assign q_pop = result_valid && !result_stall;

    tbp_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (c_valid_reg),
        .push_data (res_c),
        .pop       (q_pop),
        .valid     (result_valid),
        .head      (result),
        .count     (q_count)
    );

endmodule

`default_nettype wire

/* rtl/tbp_checker.sv */
// ----------------------------------------------------------------------------
// tbp_checker
// Port-level checks of the branch predictor: no result without a
// transfer, bound on outstanding branches, latency when empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tournament_branch_predictor_assert.svh"

module tbp_checker
    import tbp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        branch_valid,
    input wire logic        branch_stall,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire tbp_result_t result
);

    logic       branch_xfer;
    logic       result_xfer;
    logic [3:0] pend_reg, pend_next;

    // branches taken in and not yet delivered
    assign branch_xfer = branch_valid && !branch_stall;
    assign result_xfer = result_valid && !result_stall;

    always_comb
    begin
        pend_next = pend_reg + {3'b000, branch_xfer} - {3'b000, result_xfer};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // no result without a branch behind it
    `TBP_ASSERT_IMP(a_no_spurious, result_valid, pend_reg != 4'd0, "result without branch")

    // the result queue bounds the branches outstanding
    `TBP_ASSERT_IMP(a_pend_bound, 1'b1, pend_reg <= 4'(OUTQ_DEPTH), "too many outstanding")

    // an empty block delivers the result through stages b and c and the result queue
    `TBP_ASSERT_IMP(a_latency, branch_xfer && (pend_reg == 4'd0), ##3 result_valid, "late result")

    // a stalled result holds
    `TBP_ASSERT_NXT(a_hold, result_valid && result_stall, result_valid && $stable(result), "result dropped")

endmodule

bind tournament_branch_predictor tbp_checker u_tbp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .branch_valid (branch_valid),
    .branch_stall (branch_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

/* verif/tbp_checker.sv */
// ----------------------------------------------------------------------------
// tbp_scoreboard
// Watches the branch, result and cfg channels of the tournament branch
// predictor. It keeps its own copy of the three counter tables and both
// histories, works out the result of every branch transfer and compares each
// result transfer, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tbp_scoreboard
    import tbp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4096,
    parameter int HISTORY_BITS  = 12
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        branch_valid,
    input  wire logic        branch_stall,
    input  wire tbp_branch_t branch,
    input  wire logic        result_valid,
    input  wire logic        result_stall,
    input  wire tbp_result_t result,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire cfg_t        cfg_data,
    output int               mismatches,
    output int               outstanding,
    output int               branches_seen,
    output int               gshare_picks,
    output int               misses,
    output int               width_writes
);

    // shadow predictor state
    ctr_t                    bim_ctr [TABLE_ENTRIES];
    ctr_t                    gsh_ctr [TABLE_ENTRIES];
    ctr_t                    sel_ctr [TABLE_ENTRIES];
    logic [HISTORY_BITS-1:0] gsh_hist;
    logic [HISTORY_BITS-1:0] sel_hist;
    cfg_t                    width_reg;

    // outcomes predicted for branches whose result has not yet come out
    tbp_result_t predicted_results[$];

    int fail_count;
    int branch_count;
    int gshare_count;
    int miss_count;
    int write_count;

    // out-of-range widths behave as the nearest legal width
    function automatic int effective_width(input cfg_t w);
        if (w < CFG_MIN) begin
            return int'(CFG_MIN);
        end
        if (w > CFG_MAX) begin
            return int'(CFG_MAX);
        end
        return int'(w);
    endfunction

    // saturating move; a counter left above the ceiling by a narrower width
    // is never raised but may still be lowered
    function automatic ctr_t nudge(input ctr_t c, input logic up, input ctr_t sat_max);
        if (up) begin
            return (c < sat_max) ? ctr_t'(c + 8'd1) : c;
        end
        return (c == '0) ? c : ctr_t'(c - 8'd1);
    endfunction

    // look up all three tables, form the result, then train
    function automatic tbp_result_t resolve_branch(input tbp_branch_t b);
        int unsigned word;
        int unsigned gi;
        int unsigned ci;
        int          n;
        ctr_t        half;
        ctr_t        sat_max;
        logic        bim_says;
        logic        gsh_says;
        logic        pick_gshare;
        logic        bim_right;
        logic        gsh_right;
        tbp_result_t r;
        n           = effective_width(width_reg);
        half        = ctr_t'(1 << (n - 1));
        sat_max     = ctr_t'((1 << n) - 1);
        word        = (b.branch_address >> WORD_LSB) & (TABLE_ENTRIES - 1);
        gi          = (word ^ int'(gsh_hist)) & (TABLE_ENTRIES - 1);
        ci          = (word ^ int'(sel_hist)) & (TABLE_ENTRIES - 1);
        bim_says    = bim_ctr[word] >= half;
        gsh_says    = gsh_ctr[gi] >= half;
        pick_gshare = sel_ctr[ci] >= half;
        bim_right   = bim_says == b.taken;
        gsh_right   = gsh_says == b.taken;

        r.predicted_taken = pick_gshare ? gsh_says : bim_says;
        r.mispredicted    = r.predicted_taken != b.taken;
        r.used_gshare     = pick_gshare;

        // only the chosen component learns
        if (pick_gshare) begin
            gsh_ctr[gi] = nudge(gsh_ctr[gi], b.taken, sat_max);
            gsh_hist    = {gsh_hist[HISTORY_BITS-2:0], b.taken};
        end
        else begin
            bim_ctr[word] = nudge(bim_ctr[word], b.taken, sat_max);
        end

        // chooser leans toward whichever component alone was right
        if (gsh_right && !bim_right) begin
            sel_ctr[ci] = nudge(sel_ctr[ci], 1'b1, sat_max);
        end
        if (bim_right && !gsh_right) begin
            sel_ctr[ci] = nudge(sel_ctr[ci], 1'b0, sat_max);
        end
        sel_hist = {sel_hist[HISTORY_BITS-2:0], b.taken};
        return r;
    endfunction

    // track transfers on all three channels
    always @(posedge clk or negedge rst_n) begin
        tbp_result_t want;
        if (!rst_n) begin
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                bim_ctr[k] = '0;
                gsh_ctr[k] = '0;
                sel_ctr[k] = '0;
            end
            gsh_hist     = '0;
            sel_hist     = '0;
            width_reg    = CFG_RESET;
            predicted_results.delete();
            fail_count   = 0;
            branch_count = 0;
            gshare_count = 0;
            miss_count   = 0;
            write_count  = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                width_reg = cfg_data;
                write_count++;
            end

            if (branch_valid && !branch_stall) begin
                want = resolve_branch(branch);
                predicted_results.push_back(want);
                branch_count++;
                if (want.used_gshare) begin
                    gshare_count++;
                end
                if (want.mispredicted) begin
                    miss_count++;
                end
            end

            if (result_valid && !result_stall) begin
                if (predicted_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result transfer: taken=%0b miss=%0b gshare=%0b",
                                 result.predicted_taken, result.mispredicted,
                                 result.used_gshare);
                    end
                end
                else begin
                    want = predicted_results.pop_front();
                    if (result.predicted_taken !== want.predicted_taken ||
                        result.mispredicted !== want.mispredicted ||
                        result.used_gshare !== want.used_gshare) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("result mismatch: expected taken=%0b miss=%0b gshare=%0b, %s",
                                     want.predicted_taken, want.mispredicted,
                                     want.used_gshare,
                                     $sformatf("got taken=%0b miss=%0b gshare=%0b",
                                               result.predicted_taken,
                                               result.mispredicted,
                                               result.used_gshare));
                        end
                    end
                end
            end
        end

        // publish after the edge so readers see a settled value
        mismatches    <= fail_count;
        outstanding   <= predicted_results.size();
        branches_seen <= branch_count;
        gshare_picks  <= gshare_count;
        misses        <= miss_count;
        width_writes  <= write_count;
    end

endmodule

/* verif/tb_tournament_branch_predictor.sv */
// ----------------------------------------------------------------------------
// tb_tournament_branch_predictor
// Drives resolved branches into the tournament branch predictor: a directed
// opening on address extremes and counter widths shrunk under trained
// counters, then loop-like traces with random noise across several widths.
// Sender bursts and receiver stalls are random; tbp_scoreboard does the scoring.
// ----------------------------------------------------------------------------
module tb_tournament_branch_predictor;
    import tbp_pkg::*;

    localparam int TABLE_ENTRIES = 4096;
    localparam int HISTORY_BITS  = 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int POOL_SIZE     = 16;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 75;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 60;

    logic        clk;
    logic        rst_n;
    logic        branch_valid;
    logic        branch_stall;
    tbp_branch_t branch;
    logic        result_valid;
    logic        result_stall;
    tbp_result_t result;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_t        cfg_data;

    int mismatches;
    int outstanding;
    int branches_seen;
    int gshare_picks;
    int misses;
    int width_writes;
    int cycle_count = 0;
    int burst_left  = 0;

    // branch sites of the synthetic program trace
    logic [PC_W-1:0] site_pc    [POOL_SIZE];
    int              site_trip  [POOL_SIZE];
    int              site_visit [POOL_SIZE];
    logic            site_last  [POOL_SIZE];

    tournament_branch_predictor #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .HISTORY_BITS  (HISTORY_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .branch_valid (branch_valid),
        .branch_stall (branch_stall),
        .branch       (branch),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    tbp_scoreboard #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .HISTORY_BITS  (HISTORY_BITS)
    ) u_scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .branch_valid  (branch_valid),
        .branch_stall  (branch_stall),
        .branch        (branch),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .branches_seen (branches_seen),
        .gshare_picks  (gshare_picks),
        .misses        (misses),
        .width_writes  (width_writes)
    );

    // clock
    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tournament_branch_predictor test failed");
            $finish;
        end
    end

    // offer one branch, opening a new burst with a random gap when one ends
    task automatic offer_branch(input logic [PC_W-1:0] pc, input logic outcome);
        tbp_branch_t b;
        int          gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                branch_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        b.branch_address = pc;
        b.taken          = outcome;
        branch_valid    <= 1'b1;
        branch          <= b;
        @(posedge clk);
        while (branch_stall) @(posedge clk);
        burst_left--;
    endtask

    // stop offering and let every outstanding result come out
    task automatic drain_results();
        branch_valid <= 1'b0;
        burst_left    = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // counter width write
    task automatic write_width(input cfg_t w);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: stall segments of varying density, plus long hold-offs
    initial begin
        int span;
        int odds;
        int hold_at;
        hold_at = 150;
        result_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (branches_seen >= hold_at) begin
                // long hold so the result queue fills and the input backs up
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_at += 200;
            end
            else begin
                span = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0:       odds = 0;
                    1:       odds = 30;
                    default: odds = 70;
                endcase
                repeat (span) begin
                    result_stall <= ($urandom_range(0, 99) < odds);
                    @(posedge clk);
                end
            end
        end
    end

    // stimulus
    initial begin
        logic [PC_W-1:0] hot_pc;
        logic            outcome;
        int              slot;
        cfg_t            phase_width [PHASES];

        rst_n        <= 1'b0;
        branch_valid <= 1'b0;
        branch       <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;

        phase_width = '{CFG_MIN, 4'd15, 4'd0, CFG_MAX, 4'd3, 4'd0};
        phase_width[PHASES-1] = cfg_t'($urandom_range(0, 15));
        for (int s = 0; s < POOL_SIZE; s++) begin
            site_pc[s]    = $urandom;
            site_trip[s]  = $urandom_range(2, 7);
            site_visit[s] = 0;
            site_last[s]  = 1'b0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // widest counters; train one bimodal entry well past the 2-bit range
        write_width(CFG_MAX);
        hot_pc = 32'h0000_1000;
        repeat (6) offer_branch(hot_pc, 1'b1);

        // address extremes, including aliases of word index zero
        offer_branch(32'hFFFF_FFFF, 1'b0);
        offer_branch(32'h0000_0000, 1'b1);
        offer_branch(32'h0000_0003, 1'b0);
        offer_branch(32'hFFFF_C000, 1'b1);
        offer_branch(32'h0000_3FFC, 1'b0);
        offer_branch(32'h8000_0000, 1'b1);

        // width below range acts as 2; the trained counter now sits above the top
        drain_results();
        write_width(4'd0);
        repeat (3) offer_branch(hot_pc, 1'b0);
        offer_branch(hot_pc, 1'b1);

        // width above range acts as 8
        drain_results();
        write_width(4'd15);
        offer_branch(hot_pc, 1'b1);
        offer_branch(32'hFFFF_FFFF, 1'b1);

        // loop-like traces with noise, one width per phase
        slot = 0;
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            write_width(phase_width[phase]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 4) == 0) begin
                    offer_branch($urandom, 1'($urandom_range(0, 1)));
                end
                else begin
                    if ($urandom_range(0, 7) == 0) begin
                        slot = $urandom_range(0, POOL_SIZE - 1);
                    end
                    else begin
                        slot = (slot + 1) % POOL_SIZE;
                    end
                    site_visit[slot]++;
                    // loop exits, strongly biased sites, and sites that follow a neighbour
                    case (slot % 3)
                        0:       outcome = (site_visit[slot] % site_trip[slot]) != 0;
                        1:       outcome = $urandom_range(0, 9) != 0;
                        default: outcome = site_last[(slot + POOL_SIZE - 1) % POOL_SIZE];
                    endcase
                    site_last[slot] = outcome;
                    offer_branch(site_pc[slot], outcome);
                end
            end
        end

        drain_results();
        $display("covered %0d branches over %0d counter-width writes, %0d chosen by gshare",
                 branches_seen, width_writes, gshare_picks);
        $display("%0d mispredictions observed, with long result hold-offs under load",
                 misses);
        if (mismatches == 0) begin
            $display("tournament_branch_predictor test passed");
        end
        else begin
            $display("tournament_branch_predictor test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tbp_pkg.sv
rtl/tbp_ram.sv
rtl/tbp_outq.sv
rtl/tournament_branch_predictor.sv
rtl/tbp_checker.sv
verif/tbp_checker.sv
verif/tb_tournament_branch_predictor.sv
